[sv/mala_pkg.sv]
package mala_pkg;

  localparam int WINDOW_LOG2  = 4;
  localparam int WINDOW_DEPTH = 1 << WINDOW_LOG2;
  localparam int SAMPLE_BITS  = 10;
  localparam int SUM_BITS     = SAMPLE_BITS + WINDOW_LOG2;
  localparam int LIMIT_BITS   = 10;
  localparam int LEVEL_BITS   = 5;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [LIMIT_BITS-1:0]   limit_t;
  typedef logic [LEVEL_BITS-1:0]   level_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  typedef struct packed {
    limit_t one;
    limit_t two;
    limit_t three;
    limit_t four;
  } limits_t;

  localparam cfg_idx_t REG_LEVEL_ONE   = 2'd0;
  localparam cfg_idx_t REG_LEVEL_TWO   = 2'd1;
  localparam cfg_idx_t REG_LEVEL_THREE = 2'd2;
  localparam cfg_idx_t REG_LEVEL_FOUR  = 2'd3;

  localparam limit_t LIMIT_ONE_RST   = 10'd200;
  localparam limit_t LIMIT_TWO_RST   = 10'd400;
  localparam limit_t LIMIT_THREE_RST = 10'd600;
  localparam limit_t LIMIT_FOUR_RST  = 10'd800;

  localparam level_t LEVEL_ONE   = 5'b00001;
  localparam level_t LEVEL_TWO   = 5'b00010;
  localparam level_t LEVEL_THREE = 5'b00100;
  localparam level_t LEVEL_FOUR  = 5'b01000;
  localparam level_t LEVEL_OVER  = 5'b10000;

endpackage

[sv/mala_cell.sv]
module mala_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  mala_pkg::sample_t d_in,
  output mala_pkg::sample_t q
);
  import mala_pkg::*;

  sample_t q_r;
  sample_t q_nxt;

  always_comb begin
    q_nxt = shift_en ? d_in : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[sv/mala_band.sv]
module mala_band (
  input  mala_pkg::sample_t avg,
  input  mala_pkg::limits_t limits,
  output mala_pkg::level_t  level
);
  import mala_pkg::*;

  // first limit that holds decides
  always_comb begin
    if (avg <= limits.one) begin
      level = LEVEL_ONE;
    end else if (avg <= limits.two) begin
      level = LEVEL_TWO;
    end else if (avg <= limits.three) begin
      level = LEVEL_THREE;
    end else if (avg <= limits.four) begin
      level = LEVEL_FOUR;
    end else begin
      level = LEVEL_OVER;
    end
  end

endmodule

[sv/moving_average_level_meter.sv]
// channel | dir | handshake            | payload
// in      | in  | in_valid/in_ready    | in_sample[9:0]
// out     | out | out_valid/out_ready  | out_level_onehot[4:0], out_average[9:0]
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index[1:0], cfg_data[9:0]
//
// one sample per clock while in_ready is high; the result is registered and appears in the cycle after its input beat
// the sixteen history cells shift on each input beat, the sum updates in the same cycle
// reset clears history, sum and output valid; limits return to 200/400/600/800
// in_ready falls only while a result is held and out_ready is low
// cfg_ready is always high
module moving_average_level_meter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mala_pkg::sample_t    in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mala_pkg::level_t     out_level_onehot,
  output mala_pkg::sample_t    out_average,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  mala_pkg::cfg_idx_t   cfg_index,
  input  mala_pkg::limit_t     cfg_data
);
  import mala_pkg::*;

  sample_t tap [WINDOW_DEPTH];
  logic    in_beat;

  sum_t    sum_r;
  sum_t    sum_nxt;
  limits_t limits_r;
  limits_t limits_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  level_t  out_level_r;
  sample_t out_average_r;
  sample_t avg_nxt;
  level_t  level_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        mala_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (in_beat),
          .d_in     (in_sample),
          .q        (tap[g])
        );
      end else begin : g_body
        mala_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (in_beat),
          .d_in     (tap[g-1]),
          .q        (tap[g])
        );
      end
    end
  endgenerate

  always_comb begin
    sum_nxt = sum_r;
    if (in_beat) begin
      sum_nxt = sum_r + sum_t'(in_sample) - sum_t'(tap[WINDOW_DEPTH-1]);
    end
  end

  assign avg_nxt = sum_nxt[SUM_BITS-1:WINDOW_LOG2];

  mala_band u_band (
    .avg    (avg_nxt),
    .limits (limits_r),
    .level  (level_nxt)
  );

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LEVEL_ONE:   limits_nxt.one   = cfg_data;
        REG_LEVEL_TWO:   limits_nxt.two   = cfg_data;
        REG_LEVEL_THREE: limits_nxt.three = cfg_data;
        REG_LEVEL_FOUR:  limits_nxt.four  = cfg_data;
        default:         limits_nxt       = limits_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_beat) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      limits_r    <= '{one: LIMIT_ONE_RST, two: LIMIT_TWO_RST,
                       three: LIMIT_THREE_RST, four: LIMIT_FOUR_RST};
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      limits_r    <= limits_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_level_r   <= level_nxt;
      out_average_r <= avg_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level_onehot = out_level_r;
  assign out_average      = out_average_r;

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_valid_r)
    else $error("input beat without result");

  a_avg_tracks_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_average_r == sum_r[SUM_BITS-1:WINDOW_LOG2])
    else $error("average does not match running sum");

  a_level_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_level_r))
    else $error("level not one-hot");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("stalled with empty output register");

  a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_beat |=> $stable(sum_r))
    else $error("sum moved without input beat");

endmodule
